// ===== src/sdf_pkg.sv =====
// Shared types for the stream duplicate filter.
`timescale 1ns / 1ps

package sdf_pkg;

    localparam int unsigned VALUE_W = 32;

    // One word as it travels down the chain of cells, with the flags that
    // the cells it has already passed have gathered.
    typedef struct packed {
        logic                      valid;
        logic signed [VALUE_W-1:0] value;
        logic                      last;
        logic                      hit;     // matched an entry upstream
        logic                      stored;  // written into an upstream entry
    } sdf_item_t;

endpackage

// ===== src/stream_duplicate_filter.sv =====
// A word is registered in every cell's slot in turn, from the first at its accept edge
// to the last, whose slot drives the output.
// Throughput: one word per cycle; the chain moves in lockstep, so a stalled
// output word holds the whole chain (one more word can enter an empty first slot).
// Reset: rst_n is asynchronous and active low; it empties every entry and
// every pipeline slot. Entry values are not cleared, only their valid bits.
`timescale 1ns / 1ps

module stream_duplicate_filter
    import sdf_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 64
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [VALUE_W-1:0] value,
    input  logic                      last,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [VALUE_W-1:0] value_out,
    output logic                      keep,
    output logic                      set_full,
    output logic                      last_out
);

    // The seen set is spread over a row of cells, one entry per cell. Every
    // word walks down the row one cell per cycle while the chain moves. Each
    // cell compares the word with its own entry and, if the word is new and
    // the entry is free, takes the value. Words stay in order, so a word
    // always reaches a cell after every earlier word has left it, and sees
    // exactly the entries that the earlier words of its sequence wrote.
    // Entries fill from the front, so those a word sees valid are a prefix.
    //
    // The word marked last clears each entry as it passes, so words of the
    // next sequence, which trail behind it, see an empty set.

    sdf_item_t              stage_in  [TABLE_DEPTH];
    sdf_item_t              stage_out [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] entry_valid;
    logic                   advance;
    logic                   head_en;
    sdf_item_t              tail;

    assign tail = stage_out[TABLE_DEPTH-1];

    // The chain moves when the output slot is empty or being taken. The
    // first slot may also load on its own while it is empty.
    assign advance  = !tail.valid || out_ready;
    assign head_en  = advance || !stage_out[0].valid;
    assign in_ready = head_en;

    // A word enters the chain with no hit and no stored flag.
    assign stage_in[0] = {in_valid, value, last, 1'b0, 1'b0};

    generate
        for (genvar k = 0; k < TABLE_DEPTH; k++)
        begin : g_cell
            if (k > 0)
            begin : g_link
                assign stage_in[k] = stage_out[k-1];
            end

            sdf_cell u_cell
            (
                .clk         (clk),
                .rst_n       (rst_n),
                .en          ((k == 0) ? head_en : advance),
                .item_in     (stage_in[k]),
                .item_out    (stage_out[k]),
                .entry_valid (entry_valid[k])
            );
        end
    endgenerate

    // A word that hit nothing and found no free entry met a full set: it is
    // still a first occurrence, so it is kept, and the overflow is flagged.
    assign out_valid = tail.valid;
    assign value_out = tail.value;
    assign keep      = !tail.hit;
    assign set_full  = !tail.hit && !tail.stored;
    assign last_out  = tail.last;

    // An overflow word is always a kept word.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && set_full |-> keep)
        else $error("set_full raised on a dropped word");

    // With nothing waiting at the output, the filter must take input.
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with an empty output slot");

    // A word in the next-to-last slot reaches the output when the chain moves.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && stage_out[TABLE_DEPTH-2].valid |=> out_valid)
        else $error("word lost between the last two cells");

    // A last word clears the first entry as it enters.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && last |=> !entry_valid[0])
        else $error("first entry not cleared by the last word");

endmodule

// ===== src/sdf_cell.sv =====
// One cell of the filter chain: a single seen-set entry and one pipeline slot.
`timescale 1ns / 1ps

module sdf_cell
    import sdf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  sdf_item_t item_in,
    output sdf_item_t item_out,
    output logic      entry_valid
);

    logic                      entry_valid_reg;
    logic                      entry_valid_next;
    logic signed [VALUE_W-1:0] entry_value_reg;
    logic                      item_valid_reg;
    sdf_item_t                 item_reg;
    sdf_item_t                 item_next;
    logic                      match;
    logic                      store;

    // A word is stored in the first free entry it meets, unless an earlier
    // entry already holds its value. A word marked last clears the entry.
    always_comb
    begin
        match = entry_valid_reg && (entry_value_reg == item_in.value);
        store = item_in.valid && !entry_valid_reg && !item_in.hit && !item_in.stored;

        item_next        = item_in;
        item_next.hit    = item_in.hit | match;
        item_next.stored = item_in.stored | store;

        entry_valid_next = entry_valid_reg;
        if (item_in.valid && item_in.last)
        begin
            entry_valid_next = 1'b0;
        end
        else if (store)
        begin
            entry_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= 1'b0;
            item_valid_reg  <= 1'b0;
        end
        else if (en)
        begin
            entry_valid_reg <= entry_valid_next;
            item_valid_reg  <= item_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_reg <= item_next;
            if (store)
            begin
                entry_value_reg <= item_in.value;
            end
        end
    end

    always_comb
    begin
        item_out       = item_reg;
        item_out.valid = item_valid_reg;
    end

    assign entry_valid = entry_valid_reg;

endmodule
